FILE: hw/rtl/sbadq_pkg.sv
// ----------------------------------------------------------------------------
// sbadq_pkg
// shared types, constants and the log2 table of the spectrum bin quantizer
// ----------------------------------------------------------------------------
`default_nettype none

package sbadq_pkg;

  localparam int MAG_BITS     = 32;
  localparam int MAG_FRAC     = MAG_BITS - 4;
  localparam int SUM_W        = 48;
  localparam int CNT_W        = 17;
  localparam int IDX_W        = 16;
  localparam int OUT_W        = 7;
  localparam int BIN_W        = 6;
  localparam int POS_W        = 23;
  localparam int MAX_OUT_BINS = 64;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = 2;
  localparam int L_W          = 24;
  localparam int DB_W         = 44;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_COUNT  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_COUNT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_DB     = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CEILING_DB   = 8'd3;

  // 20*log10(2) in q16
  localparam logic [19:0] DB_PER_LOG2 = 20'd394566;
  // -180 db in q32
  localparam logic signed [DB_W-1:0] DB_MIN = -44'sd773094113280;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] cnt;
    logic [BIN_W-1:0] bin;
    logic             last;
    logic             zero;
  } job_t;

  // log2(1+k/16) in q16
  function automatic logic [16:0] log2_tab(input logic [4:0] k);
    logic [16:0] v;
    case (k)
      5'd0:  v = 17'd0;
      5'd1:  v = 17'd5732;
      5'd2:  v = 17'd11136;
      5'd3:  v = 17'd16248;
      5'd4:  v = 17'd21098;
      5'd5:  v = 17'd25711;
      5'd6:  v = 17'd30109;
      5'd7:  v = 17'd34312;
      5'd8:  v = 17'd38336;
      5'd9:  v = 17'd42196;
      5'd10: v = 17'd45904;
      5'd11: v = 17'd49472;
      5'd12: v = 17'd52911;
      5'd13: v = 17'd56229;
      5'd14: v = 17'd59434;
      5'd15: v = 17'd62534;
      5'd16: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sbadq_fifo.sv
// ----------------------------------------------------------------------------
// sbadq_fifo
// short job queue between the front and back parts
// ----------------------------------------------------------------------------
`default_nettype none

module sbadq_fifo
  import sbadq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output job_t      pop_job,
  output logic      full,
  output logic      empty
);

  job_t mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full    = (count_r == (QPTR_W+1)'(QDEPTH));
  assign empty   = (count_r == '0);
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (!push && pop) count_r <= count_r - 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sbadq_front.sv
// ----------------------------------------------------------------------------
// sbadq_front
// accepts magnitudes, tracks bin boundaries and sums, queues output jobs
// ----------------------------------------------------------------------------
`default_nettype none

module sbadq_front
  import sbadq_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 restart,
  input  wire logic [IDX_W-1:0]     n_eff,
  input  wire logic [OUT_W-1:0]     m_eff,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [MAG_BITS-1:0]  in_magnitude,
  output logic                      push,
  output job_t                      push_job,
  input  wire logic                 q_full
);

  typedef enum logic [1:0] {
    FS_RUN = 2'b01,
    FS_PAD = 2'b10
  } fstate_t;

  fstate_t            state_r, state_nxt;
  logic               pend_r, pend_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   in_idx_r, in_idx_nxt;
  logic [OUT_W-1:0]   out_idx_r, out_idx_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [POS_W-1:0]   bnd_r, bnd_nxt;
  logic [BIN_W-1:0]   pad_r, pad_nxt;

  logic               pend, accept, direct, hit, straddle, lastbin;
  logic [SUM_W-1:0]   e_sum, mag_w, sum_add;
  logic [CNT_W-1:0]   e_cnt;
  logic [IDX_W-1:0]   e_in;
  logic [OUT_W-1:0]   e_out, m_last;
  logic [POS_W-1:0]   e_pos, e_bnd, pos_m, n_w;
  logic [IDX_W:0]     in_inc;

  always_comb begin
    // start of a new spectrum uses reset values of the streaming state
    pend   = pend_r || (out_idx_r >= m_eff) || (in_idx_r >= n_eff);
    n_w    = POS_W'(n_eff);
    e_sum  = pend ? '0 : sum_r;
    e_cnt  = pend ? '0 : cnt_r;
    e_in   = pend ? '0 : in_idx_r;
    e_out  = pend ? '0 : out_idx_r;
    e_pos  = pend ? '0 : pos_r;
    e_bnd  = pend ? n_w : bnd_r;
    mag_w  = SUM_W'(in_magnitude);
    sum_add = e_sum + mag_w;
    pos_m  = e_pos + POS_W'(m_eff);
    hit    = (pos_m >= e_bnd);
    straddle = (pos_m > e_bnd);
    m_last = m_eff - 7'd1;
    lastbin = (e_out == m_last);
    direct = (n_eff <= IDX_W'(m_eff));
    in_inc = {1'b0, e_in} + 1'b1;

    in_stall = !((state_r == FS_RUN) && !q_full);
    accept   = in_valid && !in_stall;

    state_nxt   = state_r;
    pend_nxt    = pend_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    in_idx_nxt  = in_idx_r;
    out_idx_nxt = out_idx_r;
    pos_nxt     = pos_r;
    bnd_nxt     = bnd_r;
    pad_nxt     = pad_r;
    push        = 1'b0;
    push_job    = '0;

    case (state_r)
      FS_RUN: begin
        if (accept) begin
          pend_nxt    = 1'b0;
          sum_nxt     = e_sum;
          cnt_nxt     = e_cnt;
          in_idx_nxt  = e_in;
          out_idx_nxt = e_out;
          pos_nxt     = e_pos;
          bnd_nxt     = e_bnd;
          if (direct) begin
            push          = 1'b1;
            push_job.sum  = mag_w;
            push_job.cnt  = CNT_W'(1);
            push_job.bin  = e_in[BIN_W-1:0];
            push_job.last = (e_in == IDX_W'(m_last));
            push_job.zero = 1'b0;
            if (in_inc >= (IDX_W+1)'(n_eff)) begin
              pend_nxt = 1'b1;
              if (in_inc < (IDX_W+1)'(m_eff)) begin
                state_nxt = FS_PAD;
                pad_nxt   = in_inc[BIN_W-1:0];
              end
            end else begin
              in_idx_nxt = in_inc[IDX_W-1:0];
              pos_nxt    = pos_m;
            end
          end else begin
            sum_nxt    = sum_add;
            cnt_nxt    = e_cnt + 1'b1;
            pos_nxt    = pos_m;
            in_idx_nxt = in_inc[IDX_W-1:0];
            if (hit) begin
              push          = 1'b1;
              push_job.sum  = sum_add;
              push_job.cnt  = e_cnt + 1'b1;
              push_job.bin  = e_out[BIN_W-1:0];
              push_job.last = lastbin;
              push_job.zero = 1'b0;
              if (lastbin) begin
                pend_nxt = 1'b1;
              end else begin
                sum_nxt     = straddle ? mag_w : '0;
                cnt_nxt     = straddle ? CNT_W'(1) : '0;
                out_idx_nxt = e_out + 1'b1;
                bnd_nxt     = e_bnd + n_w;
              end
            end
          end
        end
      end
      FS_PAD: begin
        // zero-code padding up to the last output bin
        if (!q_full) begin
          push          = 1'b1;
          push_job.sum  = '0;
          push_job.cnt  = CNT_W'(1);
          push_job.bin  = pad_r;
          push_job.last = ({1'b0, pad_r} == m_last);
          push_job.zero = 1'b1;
          if (push_job.last) state_nxt = FS_RUN;
          else pad_nxt = pad_r + 1'b1;
        end
      end
      default: begin
        state_nxt = FS_RUN;
      end
    endcase

    if (restart) begin
      pend_nxt  = 1'b1;
      state_nxt = FS_RUN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= FS_RUN;
      pend_r    <= 1'b1;
      in_idx_r  <= '0;
      out_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      pend_r    <= pend_nxt;
      in_idx_r  <= in_idx_nxt;
      out_idx_r <= out_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    cnt_r <= cnt_nxt;
    pos_r <= pos_nxt;
    bnd_r <= bnd_nxt;
    pad_r <= pad_nxt;
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sbadq_back.sv
// ----------------------------------------------------------------------------
// sbadq_back
// mean division, log2 approximation and db quantization of one job
// ----------------------------------------------------------------------------
`default_nettype none

module sbadq_back
  import sbadq_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire job_t              pop_job,
  input  wire logic              q_empty,
  output logic                   pop,
  input  wire logic [8:0]        floor_db,
  input  wire logic [7:0]        ceiling_db,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_code,
  output logic [BIN_W-1:0]       out_bin_index,
  output logic                   out_last
);

  typedef enum logic [9:0] {
    BS_IDLE  = 10'b0000000001,
    BS_DIV   = 10'b0000000010,
    BS_NORM  = 10'b0000000100,
    BS_LOGM  = 10'b0000001000,
    BS_LADD  = 10'b0000010000,
    BS_DBM   = 10'b0000100000,
    BS_QPREP = 10'b0001000000,
    BS_QSAT  = 10'b0010000000,
    BS_QDIV  = 10'b0100000000,
    BS_HOLD  = 10'b1000000000
  } bstate_t;

  bstate_t                 state_r, state_nxt;
  logic [SUM_W-1:0]        num_r, num_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt, den_r, den_nxt;
  logic [5:0]              step_r, step_nxt, p_r, p_nxt;
  logic [16:0]             base_r, base_nxt;
  logic [24:0]             prod_r, prod_nxt;
  logic signed [L_W-1:0]   l_r, l_nxt;
  logic signed [DB_W-1:0]  dbq_r, dbq_nxt;
  logic [17:0]             t_r, t_nxt, qrem_r, qrem_nxt;
  logic [7:0]              code_r, code_nxt;
  logic [BIN_W-1:0]        bin_r, bin_nxt;
  logic                    last_r, last_nxt;

  logic [CNT_W:0]          rem_sh;
  logic                    ge;
  logic [15:0]             f16;
  logic [16:0]             tab_lo, tab_hi, diff;
  logic signed [6:0]       pl;
  logic signed [9:0]       dd;
  logic signed [DB_W-1:0]  dbc, flx, x;
  logic [51:0]             x255;
  logic [17:0]             dsat, dk;

  always_comb begin
    rem_sh = {rem_r, num_r[SUM_W-1]};
    ge     = (rem_sh >= {1'b0, den_r});
    f16    = num_r[SUM_W-2 -: 16];
    tab_lo = log2_tab({1'b0, f16[15:12]});
    tab_hi = log2_tab({1'b0, f16[15:12]} + 5'd1);
    diff   = tab_hi - tab_lo;
    pl     = $signed({1'b0, p_r}) - $signed(7'(MAG_FRAC));
    dd     = $signed({{2{ceiling_db[7]}}, ceiling_db}) - $signed({floor_db[8], floor_db});
    dbc    = (dbq_r < DB_MIN) ? DB_MIN : dbq_r;
    flx    = {{(DB_W-41){floor_db[8]}}, floor_db, 32'b0};
    x      = dbc - flx;
    x255   = {x, 8'b0} - {8'b0, x};
    dsat   = {1'b0, dd[8:0], 8'b0};
    dk     = 18'(dd[8:0]) << step_r[2:0];

    state_nxt = state_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    step_nxt  = step_r;
    p_nxt     = p_r;
    base_nxt  = base_r;
    prod_nxt  = prod_r;
    l_nxt     = l_r;
    dbq_nxt   = dbq_r;
    t_nxt     = t_r;
    qrem_nxt  = qrem_r;
    code_nxt  = code_r;
    bin_nxt   = bin_r;
    last_nxt  = last_r;
    pop       = 1'b0;

    case (state_r)
      BS_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          num_nxt  = pop_job.sum;
          den_nxt  = pop_job.cnt;
          rem_nxt  = '0;
          step_nxt = 6'd47;
          bin_nxt  = pop_job.bin;
          last_nxt = pop_job.last;
          code_nxt = '0;
          state_nxt = pop_job.zero ? BS_HOLD : BS_DIV;
        end
      end
      BS_DIV: begin
        // restoring division, one quotient bit a cycle
        rem_nxt = ge ? CNT_W'(rem_sh - {1'b0, den_r}) : rem_sh[CNT_W-1:0];
        num_nxt = {num_r[SUM_W-2:0], ge};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = BS_NORM;
          p_nxt     = 6'd47;
        end
      end
      BS_NORM: begin
        // shift to the leading one
        if (num_r == '0) begin
          dbq_nxt   = DB_MIN;
          state_nxt = BS_QPREP;
        end else if (num_r[SUM_W-1]) begin
          state_nxt = BS_LOGM;
        end else begin
          num_nxt = {num_r[SUM_W-2:0], 1'b0};
          p_nxt   = p_r - 1'b1;
        end
      end
      BS_LOGM: begin
        base_nxt  = tab_lo;
        prod_nxt  = diff[12:0] * f16[11:0];
        state_nxt = BS_LADD;
      end
      BS_LADD: begin
        l_nxt = $signed({{(L_W-23){pl[6]}}, pl, 16'b0}) + $signed(L_W'(base_r))
              + $signed(L_W'(prod_r[24:12]));
        state_nxt = BS_DBM;
      end
      BS_DBM: begin
        dbq_nxt   = DB_W'(l_r * $signed({1'b0, DB_PER_LOG2}));
        state_nxt = BS_QPREP;
      end
      BS_QPREP: begin
        if (dd <= 10'sd0 || x <= 44'sd0) begin
          code_nxt  = '0;
          state_nxt = BS_HOLD;
        end else begin
          t_nxt     = x255[49:32];
          state_nxt = BS_QSAT;
        end
      end
      BS_QSAT: begin
        if (t_r >= dsat) begin
          code_nxt  = 8'd255;
          state_nxt = BS_HOLD;
        end else begin
          qrem_nxt  = t_r;
          code_nxt  = '0;
          step_nxt  = 6'd7;
          state_nxt = BS_QDIV;
        end
      end
      BS_QDIV: begin
        if (qrem_r >= dk) begin
          qrem_nxt = qrem_r - dk;
          code_nxt = code_r | (8'd1 << step_r[2:0]);
        end
        step_nxt = step_r - 1'b1;
        if (step_r == '0) state_nxt = BS_HOLD;
      end
      BS_HOLD: begin
        if (!out_stall) state_nxt = BS_IDLE;
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    step_r <= step_nxt;
    p_r    <= p_nxt;
    base_r <= base_nxt;
    prod_r <= prod_nxt;
    l_r    <= l_nxt;
    dbq_r  <= dbq_nxt;
    t_r    <= t_nxt;
    qrem_r <= qrem_nxt;
    code_r <= code_nxt;
    bin_r  <= bin_nxt;
    last_r <= last_nxt;
  end

  assign out_valid     = (state_r == BS_HOLD);
  assign out_code      = code_r;
  assign out_bin_index = bin_r;
  assign out_last      = last_r;

endmodule

`default_nettype wire

FILE: hw/rtl/spectrum_bin_average_db_quantizer_top.sv
// processing: after the request that closes it, a bin passes the mean divider, the
//   normalize shifts, the log/db steps and the quantize steps before it is offered
// throughput: one request a cycle while the 4-entry job queue has room and no padding
//   is in progress; output bins follow one at a time from the back end
// reset: synchronous active low, registers return to 1024 / 64 / -80 db / 0 db,
//   the spectrum restarts and the queue empties
// ----------------------------------------------------------------------------
// spectrum_bin_average_db_quantizer_top
// averages linear spectrum bins into output bins and codes them in db
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_bin_average_db_quantizer_top
  import sbadq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // magnitude requests
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [MAG_BITS-1:0]   in_magnitude,
  // coded output bins
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [7:0]                 out_code,
  output logic [BIN_W-1:0]           out_bin_index,
  output logic                       out_last,
  // register writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [IDX_W-1:0] input_count_r;
  logic [OUT_W-1:0] output_count_r;
  logic [8:0]       floor_db_r;
  logic [7:0]       ceiling_db_r;
  logic             restart;
  logic [IDX_W-1:0] n_eff;
  logic [OUT_W-1:0] m_eff;

  job_t push_job, pop_job;
  logic q_push, q_pop, q_full, q_empty;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  // any write to a known register restarts the spectrum
  always_comb begin
    case (cfg_index)
      REG_INPUT_COUNT, REG_OUTPUT_COUNT, REG_FLOOR_DB, REG_CEILING_DB: begin
        restart = cfg_valid;
      end
      default: begin
        restart = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      input_count_r  <= 16'd1024;
      output_count_r <= 7'd64;
      floor_db_r     <= 9'h1b0;
      ceiling_db_r   <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_INPUT_COUNT:  input_count_r  <= cfg_data;
        REG_OUTPUT_COUNT: output_count_r <= cfg_data[OUT_W-1:0];
        REG_FLOOR_DB:     floor_db_r     <= cfg_data[8:0];
        REG_CEILING_DB:   ceiling_db_r   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // zero input count counts as one, output count clipped to 1..64
  assign n_eff = (input_count_r == '0) ? IDX_W'(1) : input_count_r;
  always_comb begin
    if (output_count_r == '0) begin
      m_eff = OUT_W'(1);
    end else if (output_count_r > OUT_W'(MAX_OUT_BINS)) begin
      m_eff = OUT_W'(MAX_OUT_BINS);
    end else begin
      m_eff = output_count_r;
    end
  end

  // front: bin boundaries and linear sums
  sbadq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .restart      (restart),
    .n_eff        (n_eff),
    .m_eff        (m_eff),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_magnitude (in_magnitude),
    .push         (q_push),
    .push_job     (push_job),
    .q_full       (q_full)
  );

  // job queue decouples the two halves
  sbadq_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // back: mean, log2, db code
  sbadq_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_job       (pop_job),
    .q_empty       (q_empty),
    .pop           (q_pop),
    .floor_db      (floor_db_r),
    .ceiling_db    (ceiling_db_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_code      (out_code),
    .out_bin_index (out_bin_index),
    .out_last      (out_last)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full)) else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_pop && q_empty)) else $error("job popped from empty queue");

  a_no_pop_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !q_pop) else $error("job taken while output bin pending");
`endif

endmodule

`default_nettype wire
